>>> hw/rtl/chb_pkg.sv
// Shared types, codes and defaults for the canonical Huffman build/decode block.
// No dependencies; RTL files use scoped names, testbench files import it.
`timescale 1ns / 1ps

package chb_pkg;

   localparam int MAX_ENTRIES_DEF  = 288;
   localparam int MAX_CODE_LEN_DEF = 15;

   localparam int LEN_W     = 4;
   localparam int SYM_W     = 9;
   localparam int CODE_W    = 15;
   localparam int FIRST_W   = 16;
   localparam int LIMIT_W   = 17;
   localparam int LEN_SLOTS = 16;

   localparam logic [2:0] ST_TAKEN    = 3'd0;
   localparam logic [2:0] ST_FOUND    = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_BUILD_OK = 3'd3;
   localparam logic [2:0] ST_OVERSUB  = 3'd4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [SYM_W-1:0] symbol_value;
      logic [LEN_W-1:0] code_length;
      logic             last_entry;
      logic             code_bit;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [SYM_W-1:0] symbol;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic decode;
      logic cnt_rd;
      logic cnt_wr;
      logic first_step;
      logic lim_step;
      logic sort_rd;
      logic sort_wr;
      logic build_out;
      logic dec_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_op;
      logic req_last;
      logic idx_last;
      logic first_done;
      logic lim_done;
      logic rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/chb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module chb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/chb_ctrl.sv
// Sequencer for load, table build passes, decode and result hand-off.
// Depends on chb_pkg (cmd_type, sts_type, OP_DECODE).
`timescale 1ns / 1ps

module chb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chb_pkg::sts_type sts,
   output chb_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CNT_RD    = 4'd1;
   localparam logic [3:0] S_CNT_WR    = 4'd2;
   localparam logic [3:0] S_FIRST     = 4'd3;
   localparam logic [3:0] S_LIMIT     = 4'd4;
   localparam logic [3:0] S_SORT_RD   = 4'd5;
   localparam logic [3:0] S_SORT_WR   = 4'd6;
   localparam logic [3:0] S_BUILD_OUT = 4'd7;
   localparam logic [3:0] S_DEC_OUT   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (sts.req_op == chb_pkg::OP_DECODE) begin
                  cmd.decode = 1'b1;
                  state_in   = S_DEC_OUT;
               end else begin
                  cmd.load = 1'b1;
                  if (sts.req_last) begin
                     state_in = S_CNT_RD;
                  end
               end
            end
         end
         S_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_CNT_WR;
         end
         S_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = sts.idx_last ? S_FIRST : S_CNT_RD;
         end
         S_FIRST: begin
            cmd.first_step = 1'b1;
            if (sts.first_done) begin
               state_in = S_LIMIT;
            end
         end
         S_LIMIT: begin
            cmd.lim_step = 1'b1;
            if (sts.lim_done) begin
               state_in = S_SORT_RD;
            end
         end
         S_SORT_RD: begin
            cmd.sort_rd = 1'b1;
            state_in    = S_SORT_WR;
         end
         S_SORT_WR: begin
            cmd.sort_wr = 1'b1;
            state_in    = sts.idx_last ? S_BUILD_OUT : S_SORT_RD;
         end
         S_BUILD_OUT: begin
            if (sts.rsp_free) begin
               cmd.build_out = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DEC_OUT: begin
            if (sts.rsp_free) begin
               cmd.dec_out = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/chb_dp.sv
// Datapath: entry and sorted-symbol RAMs, per-length tables, decode compare,
// result register. Depends on chb_pkg and chb_ram.
`timescale 1ns / 1ps

module chb_dp #(
   parameter int MAX_ENTRIES  = chb_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_CODE_LEN = chb_pkg::MAX_CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  chb_pkg::req_type req_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output chb_pkg::rsp_type rsp_data,
   input  chb_pkg::cmd_type cmd,
   output chb_pkg::sts_type sts
);

   localparam int NW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int LW = chb_pkg::LEN_W;
   localparam int SW = chb_pkg::SYM_W;
   localparam int CW = chb_pkg::CODE_W;
   localparam int FW = chb_pkg::FIRST_W;
   localparam int MW = chb_pkg::LIMIT_W;
   localparam int NS = chb_pkg::LEN_SLOTS;
   localparam int EW = LW + SW;
   localparam logic [NW-1:0] MAX_N  = NW'(MAX_ENTRIES);
   localparam logic [LW-1:0] MAX_L  = LW'(MAX_CODE_LEN);
   localparam logic [LW:0]   MAX_L5 = (LW + 1)'(MAX_CODE_LEN);
   localparam logic [LW-1:0] TOP_L  = LW'(NS - 1);

   // scalar state
   logic [NW-1:0]     loaded_ff, loaded_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              ready_ff, ready_in;
   logic              bad_ff, bad_in;
   logic [CW-1:0]     partial_ff, partial_in;
   logic [LW-1:0]     bits_ff, bits_in;
   logic signed [17:0] left_ff, left_in;
   logic [FW-1:0]     code_run_ff, code_run_in;
   logic [NW-1:0]     base_run_ff, base_run_in;
   logic [LW-1:0]     step_ff, step_in;
   logic [LW-1:0]     lim_ff, lim_in;
   logic [MW-1:0]     lim_run_ff, lim_run_in;
   logic [2:0]        dec_st_ff, dec_st_in;
   logic              dec_found_ff, dec_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   chb_pkg::rsp_type  rsp_ff, rsp_in;

   // per-length tables
   logic [NW-1:0] cnt_ff   [NS];
   logic [NW-1:0] cnt_in   [NS];
   logic [FW-1:0] first_ff [NS];
   logic [FW-1:0] first_in [NS];
   logic [NW-1:0] base_ff  [NS];
   logic [NW-1:0] base_in  [NS];
   logic [NW-1:0] ptr_ff   [NS];
   logic [NW-1:0] ptr_in   [NS];
   logic [MW-1:0] limit_ff [NS];
   logic [MW-1:0] limit_in [NS];

   // RAM ports
   logic          ent_we, ent_re;
   logic [IW-1:0] ent_waddr, ent_raddr;
   logic [EW-1:0] ent_wdata, ent_rdata;
   logic          srt_we;
   logic [IW-1:0] srt_waddr, srt_raddr;
   logic [SW-1:0] srt_wdata, srt_rdata;

   logic [LW-1:0] rd_len;
   logic [SW-1:0] rd_sym;
   logic          rd_live;

   // shared table read port
   logic [LW-1:0] tab_idx;
   logic [NW-1:0] cnt_sel, base_sel, ptr_sel;
   logic [FW-1:0] first_sel;
   logic [MW-1:0] lim_sel;

   // decode
   logic [LW:0]   dec_len;
   logic          dec_over;
   logic [CW-1:0] dec_code;
   logic          dec_ge;
   logic [MW-1:0] dec_diff;
   logic          dec_hit;
   logic          dec_live;
   logic [MW-1:0] dec_off;

   logic rsp_take;

   assign rd_len  = ent_rdata[EW-1:SW];
   assign rd_sym  = ent_rdata[SW-1:0];
   assign rd_live = (rd_len != '0) && (rd_len <= MAX_L);

   always_comb begin
      if (cmd.cnt_wr || cmd.sort_wr) begin
         tab_idx = rd_len;
      end else if (cmd.first_step) begin
         tab_idx = step_ff;
      end else if (cmd.lim_step) begin
         tab_idx = lim_ff;
      end else begin
         tab_idx = dec_len[LW-1:0];
      end
   end

   assign cnt_sel   = cnt_ff[tab_idx];
   assign first_sel = first_ff[tab_idx];
   assign base_sel  = base_ff[tab_idx];
   assign ptr_sel   = ptr_ff[tab_idx];
   assign lim_sel   = limit_ff[tab_idx];

   assign dec_len  = {1'b0, bits_ff} + (LW + 1)'(1);
   assign dec_over = (dec_len > MAX_L5);
   assign dec_code = {partial_ff[CW-2:0], req_data.code_bit};
   assign dec_ge   = ({1'b0, dec_code} >= first_sel);
   assign dec_diff = MW'(dec_code) - MW'(first_sel);
   assign dec_hit  = dec_ge && (dec_diff[FW-1:0] < FW'(cnt_sel));
   assign dec_live = (MW'(dec_code) < lim_sel);
   assign dec_off  = MW'(base_sel) + dec_diff;

   assign ent_we    = cmd.load && (loaded_ff < MAX_N);
   assign ent_waddr = loaded_ff[IW-1:0];
   assign ent_wdata = {req_data.code_length, req_data.symbol_value};
   assign ent_re    = cmd.cnt_rd || cmd.sort_rd;
   assign ent_raddr = idx_ff;

   assign srt_we    = cmd.sort_wr && rd_live;
   assign srt_waddr = ptr_sel[IW-1:0];
   assign srt_wdata = rd_sym;
   assign srt_raddr = dec_off[IW-1:0];

   chb_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .re    (ent_re),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   chb_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_sorted_ram (
      .clock (clock),
      .we    (srt_we),
      .waddr (srt_waddr),
      .wdata (srt_wdata),
      .re    (cmd.decode),
      .raddr (srt_raddr),
      .rdata (srt_rdata)
   );

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign sts.req_op     = req_data.operation;
   assign sts.req_last   = req_data.last_entry;
   assign sts.idx_last   = (NW'(idx_ff) == n_ff - NW'(1));
   assign sts.first_done = (step_ff == TOP_L);
   assign sts.lim_done   = (lim_ff == LW'(1));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [FW:0]        code_sum;
      logic signed [17:0] left_nx;
      logic [MW:0]        lim_half;
      logic [MW-1:0]      lim_val;

      loaded_in    = loaded_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      ready_in     = ready_ff;
      bad_in       = bad_ff;
      partial_in   = partial_ff;
      bits_in      = bits_ff;
      left_in      = left_ff;
      code_run_in  = code_run_ff;
      base_run_in  = base_run_ff;
      step_in      = step_ff;
      lim_in       = lim_ff;
      lim_run_in   = lim_run_ff;
      dec_st_in    = dec_st_ff;
      dec_found_in = dec_found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      limit_in     = limit_ff;

      code_sum = (FW + 1)'(code_run_ff) + (FW + 1)'(cnt_sel);
      left_nx  = (left_ff <<< 1) - $signed(18'(cnt_sel));
      lim_half = ((MW + 1)'(lim_run_ff) + (MW + 1)'(1)) >> 1;
      lim_val  = (lim_ff == MAX_L) ? (MW'(first_sel) + MW'(cnt_sel)) : lim_half[MW-1:0];

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         ready_in   = 1'b0;
         partial_in = '0;
         bits_in    = '0;
         if (loaded_ff < MAX_N) begin
            loaded_in = loaded_ff + NW'(1);
         end
         if (req_data.last_entry) begin
            n_in        = (loaded_ff < MAX_N) ? loaded_ff + NW'(1) : loaded_ff;
            loaded_in   = '0;
            idx_in      = '0;
            bad_in      = 1'b0;
            left_in     = 18'sd1;
            code_run_in = '0;
            base_run_in = '0;
            step_in     = '0;
            lim_in      = MAX_L;
            for (int k = 0; k < NS; k++) begin
               cnt_in[k]   = '0;
               first_in[k] = '0;
               base_in[k]  = '0;
               ptr_in[k]   = '0;
            end
         end
      end

      if (cmd.cnt_wr) begin
         if (rd_len != '0) begin
            cnt_in[rd_len] = cnt_sel + NW'(1);
         end
         if (rd_len > MAX_L) begin
            bad_in = 1'b1;
         end
         idx_in = sts.idx_last ? '0 : idx_ff + IW'(1);
      end

      // one length per cycle: Kraft check, first code and base of next length
      if (cmd.first_step) begin
         if (step_ff != '0) begin
            left_in = left_nx;
            if (left_nx < 0) begin
               bad_in = 1'b1;
            end
         end
         if (step_ff != TOP_L) begin
            code_run_in = {code_sum[FW-2:0], 1'b0};
            if (step_ff < MAX_L) begin
               first_in[step_ff + LW'(1)] = {code_sum[FW-2:0], 1'b0};
            end
            base_in[step_ff + LW'(1)] = base_run_ff + cnt_sel;
            ptr_in[step_ff + LW'(1)]  = base_run_ff + cnt_sel;
         end
         base_run_in = base_run_ff + cnt_sel;
         step_in     = step_ff + LW'(1);
      end

      // live-prefix bound per depth, deepest first
      if (cmd.lim_step) begin
         limit_in[lim_ff] = lim_val;
         lim_run_in       = lim_val;
         lim_in           = lim_ff - LW'(1);
      end

      if (cmd.sort_wr) begin
         if (rd_live) begin
            ptr_in[rd_len] = ptr_sel + NW'(1);
         end
         idx_in = sts.idx_last ? '0 : idx_ff + IW'(1);
      end

      if (cmd.build_out) begin
         ready_in      = !bad_ff;
         rsp_valid_in  = 1'b1;
         rsp_in.status = bad_ff ? chb_pkg::ST_OVERSUB : chb_pkg::ST_BUILD_OK;
         rsp_in.symbol = '0;
      end

      if (cmd.decode) begin
         dec_found_in = 1'b0;
         partial_in   = '0;
         bits_in      = '0;
         if (!ready_ff || dec_over) begin
            dec_st_in = chb_pkg::ST_INVALID;
         end else if (dec_hit) begin
            dec_st_in    = chb_pkg::ST_FOUND;
            dec_found_in = 1'b1;
         end else if (dec_live) begin
            dec_st_in  = chb_pkg::ST_TAKEN;
            partial_in = dec_code;
            bits_in    = dec_len[LW-1:0];
         end else begin
            dec_st_in = chb_pkg::ST_INVALID;
         end
      end

      if (cmd.dec_out) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = dec_st_ff;
         rsp_in.symbol = dec_found_ff ? srt_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         ready_ff     <= 1'b0;
         partial_ff   <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NS; k++) begin
            cnt_ff[k]   <= '0;
            first_ff[k] <= '0;
         end
      end else begin
         loaded_ff    <= loaded_in;
         ready_ff     <= ready_in;
         partial_ff   <= partial_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      bad_ff       <= bad_in;
      left_ff      <= left_in;
      code_run_ff  <= code_run_in;
      base_run_ff  <= base_run_in;
      step_ff      <= step_in;
      lim_ff       <= lim_in;
      lim_run_ff   <= lim_run_in;
      dec_st_ff    <= dec_st_in;
      dec_found_ff <= dec_found_in;
      rsp_ff       <= rsp_in;
      base_ff      <= base_in;
      ptr_ff       <= ptr_in;
      limit_ff     <= limit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/canonical_huffman_build_and_decode.sv
// Top level: canonical Huffman table builder and bit-serial decoder.
// Depends on chb_pkg, chb_ctrl, chb_dp (which uses chb_ram).
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+------------------
//   request | req_valid, req_stall, req_data | in        | chb_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data | out       | chb_pkg::rsp_type
//
// A load without last_entry leaves the sequencer in idle, so the next request
// is taken without a stall. A decode bit is compared and its sorted-symbol RAM
// read issued, then moved to the result register once that register is free.
// A build runs a count pass over the entry RAM, 16 steps over the length table,
// MAX_CODE_LEN steps for the prefix bounds and a sort pass over the entry RAM.
// Reset is synchronous; no clearing pass, entry and symbol RAMs are written
// before they are read. A result waits in the output register while the next
// item is taken; a build or decode result is held back while that register
// is stalled.
`timescale 1ns / 1ps

module canonical_huffman_build_and_decode #(
   parameter int MAX_ENTRIES  = chb_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_CODE_LEN = chb_pkg::MAX_CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chb_pkg::rsp_type rsp_data
);

   chb_pkg::cmd_type cmd;
   chb_pkg::sts_type sts;

   // sequencer: accepts only in idle, steps the build passes
   chb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, RAMs, decode compare and output register
   chb_dp #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

>>> tb/canonical_huffman_build_and_decode_checker.sv
// Checker for the canonical Huffman build/decode block: watches both channels,
// predicts results from accepted requests and compares them. Depends on chb_pkg.
`timescale 1ns / 1ps

module canonical_huffman_build_and_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  chb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  chb_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count,
   output int               found_count,
   output int               build_count
);
   import chb_pkg::*;

   localparam int N_ENT = MAX_ENTRIES_DEF;
   localparam int N_LEN = MAX_CODE_LEN_DEF;

   logic [LEN_W-1:0] lens_mem [N_ENT];
   logic [SYM_W-1:0] syms_mem [N_ENT];
   logic [SYM_W-1:0] canon_syms [N_ENT];
   int unsigned      len_count [LEN_SLOTS];
   int unsigned      first_code [LEN_SLOTS];
   int unsigned      n_loaded;
   int unsigned      prefix;
   int unsigned      depth;
   bit               decode_ok;
   rsp_type          expected_q [$];

   function automatic bit build_code_table();
      int unsigned code, pos;
      int          room;
      bit          ok;
      ok = 1;
      for (int l = 0; l < LEN_SLOTS; l++) begin
         len_count[l] = 0;
         first_code[l] = 0;
      end
      for (int i = 0; i < n_loaded; i++) begin
         if (lens_mem[i] > N_LEN) ok = 0;
         len_count[lens_mem[i]]++;
      end
      len_count[0] = 0;
      room = 1;
      for (int l = 1; l <= 15; l++) begin
         room = room * 2 - int'(len_count[l]);
         if (room < 0) ok = 0;
      end
      code = 0;
      for (int l = 1; l <= N_LEN; l++) begin
         code = ((code + len_count[l-1]) << 1) & 16'hFFFF;
         first_code[l] = code;
      end
      pos = 0;
      for (int l = 1; l <= N_LEN; l++)
         for (int i = 0; i < n_loaded; i++)
            if (lens_mem[i] == l && pos < N_ENT) begin
               canon_syms[pos] = syms_mem[i];
               pos++;
            end
      return ok;
   endfunction

   // returns 1 when the item yields a result
   function automatic bit predict_transfer(req_type r, output rsp_type res);
      int unsigned code, len, offs, lim;
      res = '0;
      if (r.operation == OP_LOAD) begin
         decode_ok = 0;
         prefix = 0;
         depth = 0;
         if (n_loaded < N_ENT) begin
            lens_mem[n_loaded] = r.code_length;
            syms_mem[n_loaded] = r.symbol_value;
            n_loaded++;
         end
         if (!r.last_entry) return 0;
         decode_ok = build_code_table();
         n_loaded = 0;
         res.status = decode_ok ? ST_BUILD_OK : ST_OVERSUB;
         return 1;
      end
      if (!decode_ok) begin
         prefix = 0;
         depth = 0;
         res.status = ST_INVALID;
         return 1;
      end
      code = ((prefix << 1) | r.code_bit) & 15'h7FFF;
      len = depth + 1;
      prefix = 0;
      depth = 0;
      if (len > N_LEN) begin
         res.status = ST_INVALID;
         return 1;
      end
      if (code >= first_code[len] && code - first_code[len] < len_count[len]) begin
         offs = code - first_code[len];
         for (int l = 1; l < len; l++) offs += len_count[l];
         res.status = ST_FOUND;
         res.symbol = (offs < N_ENT) ? canon_syms[offs] : '0;
         return 1;
      end
      lim = first_code[N_LEN] + len_count[N_LEN];
      for (int l = N_LEN; l > len; l--) lim = (lim + 1) >> 1;
      if (code < lim) begin
         prefix = code;
         depth = len & 15;
         res.status = ST_TAKEN;
      end else begin
         res.status = ST_INVALID;
      end
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         n_loaded = 0;
         prefix = 0;
         depth = 0;
         decode_ok = 0;
         for (int l = 0; l < LEN_SLOTS; l++) begin
            len_count[l] = 0;
            first_code[l] = 0;
         end
         expected_q.delete();
         error_count = 0;
         found_count = 0;
         build_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, actual status=%0d symbol=%0d",
                        $time, rsp_data.status, rsp_data.symbol);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.symbol !== want.symbol) begin
                  error_count++;
                  $display("%0t: symbol mismatch, expected %0d actual %0d",
                           $time, want.symbol, rsp_data.symbol);
               end
               if (want.status == ST_FOUND) found_count++;
               if (want.status >= ST_BUILD_OK) build_count++;
            end
         end
         if (req_valid && !req_stall)
            if (predict_transfer(req_data, want)) expected_q.push_back(want);
      end
      pending_count = expected_q.size();
   end
endmodule

>>> tb/canonical_huffman_build_and_decode_test.sv
// Top of the testbench for canonical_huffman_build_and_decode: clock, reset,
// stimulus, receiver stalls and verdict. Depends on chb_pkg and the checker.
`timescale 1ns / 1ps

module canonical_huffman_build_and_decode_test;
   import chb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 1300;   // longest build on a full table plus slack

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      error_count, pending_count, found_count, build_count;
   int      cycle_count = 0;
   int      sent_count = 0;
   int      table_count = 0;
   bit      hold_off = 0;     // forces a long receiver stall
   bit      sender_done = 0;

   // lengths of the table currently loaded, used to form real codes
   int      cur_len [$];

   canonical_huffman_build_and_decode uut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   canonical_huffman_build_and_decode_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .error_count, .pending_count, .found_count, .build_count
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 5) reset <= 0;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, and stretches with none
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus the forced hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_off) rsp_stall <= 1;
      else rsp_stall <= (gap_len() != 0);
   end

   // one transfer: present it, wait until accepted, then optionally idle
   task automatic send_item(req_type r, bit may_gap);
      int g;
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      g = may_gap ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 0;
         req_data <= '0;   // bits left random enough by the items themselves
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_entry(int sym, int len, bit last);
      req_type r;
      r = '0;
      r.operation = OP_LOAD;
      r.symbol_value = SYM_W'(sym);
      r.code_length = LEN_W'(len);
      r.last_entry = last;
      r.code_bit = 1'($urandom_range(0, 1));
      send_item(r, 1);
   endtask

   task automatic send_bit(bit b);
      req_type r;
      r = 16'($urandom);
      r.operation = OP_DECODE;
      r.code_bit = b;
      send_item(r, 1);
   endtask

   task automatic load_table(int lens [$]);
      for (int i = 0; i < lens.size(); i++)
         send_entry($urandom_range(0, 511), lens[i], i == lens.size() - 1);
      cur_len = lens;
      table_count++;
   endtask

   // tree leaf depths, up to n, <= maxd; one dropped unless full; may add zeros
   function automatic void make_lengths(int n, int maxd, bit full, ref int lens [$]);
      int k, idx;
      lens.delete();
      lens.push_back(1);
      lens.push_back(1);
      for (k = 0; k < 4 * n && lens.size() < n; k++) begin
         idx = $urandom_range(0, lens.size() - 1);
         if (lens[idx] < maxd) begin
            lens[idx]++;
            lens.insert(idx, lens[idx]);
         end
      end
      if (!full && lens.size() > 1) lens.delete($urandom_range(0, lens.size() - 1));
      lens.shuffle();
      if ($urandom_range(0, 3) == 0)
         for (k = $urandom_range(1, 4); k > 0; k--)
            lens.insert($urandom_range(0, lens.size()), 0);
   endfunction

   // send the bits of the canonical code of entry idx
   task automatic send_codeword(int idx);
      int cnt [16];
      int code, len, nxt;
      foreach (cnt[l]) cnt[l] = 0;
      foreach (cur_len[i]) cnt[cur_len[i]]++;
      cnt[0] = 0;
      len = cur_len[idx];
      code = 0;
      for (int l = 1; l <= len; l++) code = (code + cnt[l-1]) << 1;
      nxt = 0;
      for (int i = 0; i < idx; i++) if (cur_len[i] == len) nxt++;
      code += nxt;
      for (int b = len - 1; b >= 0; b--) send_bit(code[b]);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int lens [$];
      int idx;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: decode before any table, empty table, extremes
      send_bit(0);
      send_bit(1);
      load_table('{0, 0, 0});               // no codes at all
      send_bit(1);
      send_bit(0);
      load_table('{1, 1});                  // two one-bit codes
      send_codeword(0);
      send_codeword(1);
      load_table('{1, 1, 1});               // oversubscribed
      send_bit(0);
      send_entry(511, 15, 0);               // length of fifteen, single code
      send_entry(0, 0, 1);
      cur_len = '{15, 0};
      for (int b = 0; b < 16; b++) send_bit(0);   // deepest path, then the start of the next code
      send_bit(1);                          // leaves the only prefix
      load_table('{1, 2});                  // incomplete code: invalid path
      send_bit(1);
      send_bit(1);
      wait_drained();

      // receiver holds off while the sender keeps offering
      hold_off = 1;
      fork
         begin
            load_table('{2, 2, 2, 2});
            for (int i = 0; i < 12; i++) send_codeword(i % 4);
         end
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
      join
      wait_drained();

      // overflow: more entries than the table holds; then a full-size table
      for (int i = 0; i < 290; i++) send_entry(i % 512, 9, i == 289);
      make_lengths(288, 15, 1, lens);
      while (lens.size() > 288) lens.pop_back();
      load_table(lens);
      for (int i = 0; i < 20; i++) begin
         idx = $urandom_range(0, cur_len.size() - 1);
         if (cur_len[idx] != 0) send_codeword(idx);
      end

      // random tables, mostly small, with mostly well-formed code streams
      while (sent_count < 1600) begin
         make_lengths($urandom_range(2, 24), $urandom_range(1, 15),
                      $urandom_range(0, 4) != 0, lens);
         if ($urandom_range(0, 9) == 0) lens[0] = $urandom_range(0, 15);
         load_table(lens);
         for (int i = $urandom_range(5, 25); i > 0; i--) begin
            idx = $urandom_range(0, cur_len.size() - 1);
            if ($urandom_range(0, 7) == 0) send_bit(1'($urandom_range(0, 1)));
            else if (cur_len[idx] != 0) send_codeword(idx);
         end
         if ($urandom_range(0, 30) == 0) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
      end

      req_valid <= 0;
      sender_done = 1;
   end

   initial begin
      wait (sender_done);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d tables; %0d builds and %0d symbols checked.",
               sent_count, table_count, build_count, found_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> canonical_huffman_build_and_decode.f
hw/rtl/chb_pkg.sv
hw/rtl/chb_ram.sv
hw/rtl/chb_ctrl.sv
hw/rtl/chb_dp.sv
hw/rtl/canonical_huffman_build_and_decode.sv
tb/canonical_huffman_build_and_decode_checker.sv
tb/canonical_huffman_build_and_decode_test.sv
